// ===== rtl/lfu_pkg.sv =====
// Shared types and constants for the least-frequently-used cache table.
// Used by the cell, the row of cells and the top level; no dependencies.
package lfu_pkg;

	localparam int unsigned DefaultCapacity = 16;
	localparam int unsigned CountWidth      = 16;
	localparam int unsigned CapWidth        = 5;

	localparam logic CmdGet = 1'b0;
	localparam logic CmdPut = 1'b1;

	typedef struct packed {
		logic               command;
		logic signed [31:0] key;
		logic signed [31:0] store_value;
	} lfu_req_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] read_value;
	} lfu_rsp_t;

	// Broadcast update to every cell in the row.
	typedef struct packed {
		logic        touch;    // raise count of the selected cell, make it most recent
		logic        insert;   // write a new entry into the selected cell
		logic        evict;    // selected cell leaves; close the gap in ranks
		logic [31:0] key;
		logic [31:0] value;
		logic        wr_value; // overwrite value on touch
	} lfu_upd_t;

endpackage

// ===== rtl/lfu_cell.sv =====
// One cache entry: valid flag, key, value, use count and recency rank.
// Passes the running search (match and victim candidate) to its neighbour through registers.
// Depends on lfu_pkg.
module lfu_cell #(
	parameter int unsigned RANK_W = 4,
	parameter int unsigned IDX_W  = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [IDX_W-1:0]    my_idx,
	// search chain in
	input  logic [31:0]         srch_key,
	input  logic                in_found,
	input  logic [IDX_W-1:0]    in_found_idx,
	input  logic                in_vict_ok,
	input  logic [IDX_W-1:0]    in_vict_idx,
	input  logic [lfu_pkg::CountWidth-1:0] in_vict_cnt,
	input  logic [RANK_W-1:0]   in_vict_rank,
	input  logic                in_free_ok,
	input  logic [IDX_W-1:0]    in_free_idx,
	// search chain out, registered
	output logic                out_found,
	output logic [IDX_W-1:0]    out_found_idx,
	output logic                out_vict_ok,
	output logic [IDX_W-1:0]    out_vict_idx,
	output logic [lfu_pkg::CountWidth-1:0] out_vict_cnt,
	output logic [RANK_W-1:0]   out_vict_rank,
	output logic                out_free_ok,
	output logic [IDX_W-1:0]    out_free_idx,
	output logic [31:0]         value,
	output logic [RANK_W-1:0]   rank,
	// update
	input  logic                upd_en,
	input  lfu_pkg::lfu_upd_t   upd,
	input  logic [IDX_W-1:0]    sel_idx,
	input  logic [RANK_W-1:0]   sel_rank
);
	import lfu_pkg::*;

	logic                  valid_q;
	logic [31:0]           key_q;
	logic [31:0]           value_q;
	logic [CountWidth-1:0] count_q;
	logic [RANK_W-1:0]     rank_q;
	logic                  is_sel;
	logic                  better;
	logic                  nx_found;
	logic [IDX_W-1:0]      nx_found_idx;
	logic                  nx_vict_ok;
	logic [IDX_W-1:0]      nx_vict_idx;
	logic [CountWidth-1:0] nx_vict_cnt;
	logic [RANK_W-1:0]     nx_vict_rank;
	logic                  nx_free_ok;
	logic [IDX_W-1:0]      nx_free_idx;

	assign value  = value_q;
	assign rank   = rank_q;
	assign is_sel = (my_idx == sel_idx);

	// Search: key match, first free slot, least used / oldest victim
	assign better = !in_vict_ok || (count_q < in_vict_cnt) ||
		(count_q == in_vict_cnt && rank_q > in_vict_rank);

	always_comb begin
		nx_found     = in_found;
		nx_found_idx = in_found_idx;
		if (!in_found && valid_q && key_q == srch_key) begin
			nx_found     = 1'b1;
			nx_found_idx = my_idx;
		end
		nx_free_ok  = in_free_ok;
		nx_free_idx = in_free_idx;
		if (!in_free_ok && !valid_q) begin
			nx_free_ok  = 1'b1;
			nx_free_idx = my_idx;
		end
		nx_vict_ok   = in_vict_ok;
		nx_vict_idx  = in_vict_idx;
		nx_vict_cnt  = in_vict_cnt;
		nx_vict_rank = in_vict_rank;
		if (valid_q && better) begin
			nx_vict_ok   = 1'b1;
			nx_vict_idx  = my_idx;
			nx_vict_cnt  = count_q;
			nx_vict_rank = rank_q;
		end
	end

	// Hand the running search to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_found     <= 1'b0;
			out_found_idx <= '0;
			out_vict_ok   <= 1'b0;
			out_vict_idx  <= '0;
			out_vict_cnt  <= '0;
			out_vict_rank <= '0;
			out_free_ok   <= 1'b0;
			out_free_idx  <= '0;
		end else begin
			out_found     <= nx_found;
			out_found_idx <= nx_found_idx;
			out_vict_ok   <= nx_vict_ok;
			out_vict_idx  <= nx_vict_idx;
			out_vict_cnt  <= nx_vict_cnt;
			out_vict_rank <= nx_vict_rank;
			out_free_ok   <= nx_free_ok;
			out_free_idx  <= nx_free_idx;
		end
	end

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (upd_en && is_sel && upd.insert) begin
			valid_q <= 1'b1;
		end
	end

	// Entry payload and ranks
	always_ff @(posedge clk) begin
		if (upd_en) begin
			if (is_sel) begin
				if (upd.insert) begin
					key_q   <= upd.key;
					value_q <= upd.value;
					count_q <= CountWidth'(1);
					rank_q  <= '0;
				end else if (upd.touch) begin
					if (upd.wr_value) value_q <= upd.value;
					if (count_q != {CountWidth{1'b1}}) count_q <= count_q + 1'b1;
					rank_q <= '0;
				end
			end else if (valid_q) begin
				if (upd.touch && rank_q < sel_rank) begin
					rank_q <= rank_q + 1'b1;
				end else if (upd.insert) begin
					// eviction closes the gap, then every entry ages by one
					if (upd.evict && rank_q > sel_rank) rank_q <= rank_q;
					else rank_q <= rank_q + 1'b1;
				end
			end
		end
	end

endmodule

// ===== rtl/lfu_row.sv =====
// Row of entry cells with a registered search chain through them.
// Depends on lfu_pkg and lfu_cell.
module lfu_row #(
	parameter int unsigned CAPACITY = lfu_pkg::DefaultCapacity
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [31:0]        srch_key,
	output logic               found,
	output logic [$clog2(CAPACITY > 1 ? CAPACITY : 2)-1:0] found_idx,
	output logic [$clog2(CAPACITY > 1 ? CAPACITY : 2)-1:0] found_rank,
	output logic               vict_ok,
	output logic [$clog2(CAPACITY > 1 ? CAPACITY : 2)-1:0] vict_idx,
	output logic [$clog2(CAPACITY > 1 ? CAPACITY : 2)-1:0] vict_rank,
	output logic               free_ok,
	output logic [$clog2(CAPACITY > 1 ? CAPACITY : 2)-1:0] free_idx,
	output logic [31:0]        found_value,
	input  logic               upd_en,
	input  lfu_pkg::lfu_upd_t  upd,
	input  logic [$clog2(CAPACITY > 1 ? CAPACITY : 2)-1:0] sel_idx,
	input  logic [$clog2(CAPACITY > 1 ? CAPACITY : 2)-1:0] sel_rank
);
	import lfu_pkg::*;

	localparam int unsigned IW = $clog2(CAPACITY > 1 ? CAPACITY : 2);

	logic                  f   [CAPACITY+1];
	logic [IW-1:0]         fi  [CAPACITY+1];
	logic                  vo  [CAPACITY+1];
	logic [IW-1:0]         vi  [CAPACITY+1];
	logic [CountWidth-1:0] vc  [CAPACITY+1];
	logic [IW-1:0]         vr  [CAPACITY+1];
	logic                  fo  [CAPACITY+1];
	logic [IW-1:0]         foi [CAPACITY+1];
	logic [31:0]           vals [CAPACITY];
	logic [IW-1:0]         ranks [CAPACITY];

	assign f[0]   = 1'b0;
	assign fi[0]  = '0;
	assign vo[0]  = 1'b0;
	assign vi[0]  = '0;
	assign vc[0]  = '0;
	assign vr[0]  = '0;
	assign fo[0]  = 1'b0;
	assign foi[0] = '0;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		lfu_cell #(.RANK_W(IW), .IDX_W(IW)) u_cell (
			.clk, .arst_n,
			.my_idx(IW'(g)),
			.srch_key,
			.in_found(f[g]), .in_found_idx(fi[g]),
			.in_vict_ok(vo[g]), .in_vict_idx(vi[g]),
			.in_vict_cnt(vc[g]), .in_vict_rank(vr[g]),
			.in_free_ok(fo[g]), .in_free_idx(foi[g]),
			.out_found(f[g+1]), .out_found_idx(fi[g+1]),
			.out_vict_ok(vo[g+1]), .out_vict_idx(vi[g+1]),
			.out_vict_cnt(vc[g+1]), .out_vict_rank(vr[g+1]),
			.out_free_ok(fo[g+1]), .out_free_idx(foi[g+1]),
			.value(vals[g]),
			.rank(ranks[g]),
			.upd_en, .upd, .sel_idx, .sel_rank
		);
	end

	assign found       = f[CAPACITY];
	assign found_idx   = fi[CAPACITY];
	assign vict_ok     = vo[CAPACITY];
	assign vict_idx    = vi[CAPACITY];
	assign vict_rank   = vr[CAPACITY];
	assign free_ok     = fo[CAPACITY];
	assign free_idx    = foi[CAPACITY];
	assign found_value = vals[fi[CAPACITY]];
	assign found_rank  = ranks[fi[CAPACITY]];

endmodule

// ===== rtl/lfu_cache_table_core.sv =====
// LFU cache table: top level with command handshake and capacity register.
// Depends on lfu_pkg and lfu_row.
// The search advances one cell per cycle through the row from the accepting
//   edge, then the update state decides the update and raises the strobe.
// busy stays high until a command has finished; a new one is taken only then.
// Reset: all entries invalid, occupancy zero, capacity_in_use 16. No result stall.
module lfu_cache_table_core #(
	parameter int unsigned CAPACITY = lfu_pkg::DefaultCapacity
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  lfu_pkg::lfu_req_t            req,
	output logic                         strobe,
	output lfu_pkg::lfu_rsp_t            rsp,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [lfu_pkg::CapWidth-1:0] cfg_data
);
	import lfu_pkg::*;

	localparam int unsigned IW  = $clog2(CAPACITY > 1 ? CAPACITY : 2);
	localparam int unsigned OW  = $clog2(CAPACITY + 1);
	localparam int unsigned CEW = (OW > CapWidth) ? OW : CapWidth;

	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StSrch = 2'd1;
	localparam logic [1:0] StUpd  = 2'd2;
	localparam logic [1:0] StOut  = 2'd3;

	logic [1:0]          state_q;
	logic [IW-1:0]       scan_q;
	lfu_req_t            req_q;
	logic [CapWidth-1:0] cap_q;
	logic [OW-1:0]       occ_q;
	logic                found, vict_ok, free_ok;
	logic [IW-1:0]       found_idx, found_rank, vict_idx, vict_rank, free_idx;
	logic [31:0]         found_value;
	logic                upd_en;
	lfu_upd_t            upd;
	logic [IW-1:0]       sel_idx, sel_rank;
	logic                hit_q;
	logic [31:0]         rval_q;
	logic [CEW-1:0]      cap_ext;
	logic [CEW-1:0]      cap_eff;
	logic                full;

	assign busy      = (state_q != StIdle);
	assign cfg_ready = !busy;

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CapWidth'(16);
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	assign cap_ext = CEW'(cap_q);
	assign cap_eff = (cap_ext > CEW'(CAPACITY)) ? CEW'(CAPACITY) : cap_ext;
	assign full    = (CEW'(occ_q) >= cap_eff);

	lfu_row #(.CAPACITY(CAPACITY)) u_row (
		.clk, .arst_n,
		.srch_key(req_q.key),
		.found, .found_idx, .found_rank, .vict_ok, .vict_idx, .vict_rank,
		.free_ok, .free_idx, .found_value,
		.upd_en, .upd, .sel_idx, .sel_rank
	);

	// Decide the update from the search results
	always_comb begin
		upd          = '0;
		upd.key      = req_q.key;
		upd.value    = req_q.store_value;
		upd_en       = 1'b0;
		sel_idx      = found_idx;
		sel_rank     = '0;
		if (state_q == StUpd) begin
			if (found && (req_q.command == CmdGet || cap_eff != '0)) begin
				upd_en       = 1'b1;
				upd.touch    = 1'b1;
				upd.wr_value = (req_q.command == CmdPut);
				sel_idx      = found_idx;
				sel_rank     = found_rank;
			end else if (!found && req_q.command == CmdPut && cap_eff != '0) begin
				if (full && vict_ok) begin
					upd_en     = 1'b1;
					upd.insert = 1'b1;
					upd.evict  = 1'b1;
					sel_idx    = vict_idx;
					sel_rank   = vict_rank;
				end else if (!full && free_ok) begin
					upd_en     = 1'b1;
					upd.insert = 1'b1;
					sel_idx    = free_idx;
					sel_rank   = '0;
				end
			end
		end
	end

	// Sequencer and result register; hold in search until the chain has settled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			scan_q  <= '0;
			occ_q   <= '0;
			strobe  <= 1'b0;
		end else begin
			strobe <= 1'b0;
			case (state_q)
				StIdle: begin
					if (start) begin
						state_q <= StSrch;
						scan_q  <= '0;
					end
				end
				StSrch: begin
					if (scan_q == IW'(CAPACITY - 1)) state_q <= StUpd;
					else scan_q <= scan_q + 1'b1;
				end
				StUpd: begin
					if (upd_en && upd.insert && !upd.evict) occ_q <= occ_q + 1'b1;
					state_q <= StOut;
					strobe  <= 1'b1;
				end
				StOut:   state_q <= StIdle;
				default: state_q <= StIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == StIdle && start) req_q <= req;
		if (state_q == StUpd) begin
			hit_q  <= found;
			rval_q <= (found && req_q.command == CmdGet) ? found_value : '0;
		end
	end

	assign rsp.hit        = hit_q;
	assign rsp.read_value = rval_q;

	a_strobe_one: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe) else $error("strobe longer than one cycle");
	a_busy_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy) else $error("result outside an operation");
	a_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(32)'(occ_q) <= CAPACITY) else $error("occupancy overflow");

endmodule
